// ===== src/serial_link_handshake_top_defines.svh =====
// Assertion helpers shared by the handshake RTL.
`ifndef SERIAL_LINK_HANDSHAKE_TOP_DEFINES_SVH
`define SERIAL_LINK_HANDSHAKE_TOP_DEFINES_SVH

// Property checked at every rising clock edge outside reset.
`define SLHS_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// Same-cycle implication.
`define SLHS_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define SLHS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/slhs_pkg.sv =====
package slhs_pkg;

  // Largest batch taken in one read; a batch this full never matches.
  localparam int READ_BATCH = 32;
  // Compare width for batch sizes, covers READ_BATCH up to 511.
  localparam int BATCH_CMP_W = 9;

  localparam logic [5:0]  RX_SAT    = 6'd32;
  localparam logic [15:0] TIMER_MAX = 16'hFFFF;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [2:0] {
    STEP_INIT1     = 3'd1,
    STEP_INIT2     = 3'd2,
    STEP_INIT3     = 3'd3,
    STEP_INIT4     = 3'd4,
    STEP_CONNECTED = 3'd5
  } step_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROLE_IS_SERVER     = 3'd0,
    CFG_CONNECT_PERIOD_MS  = 3'd1,
    CFG_CONNECT_CODE       = 3'd2,
    CFG_CONFIRM_CODE       = 3'd3,
    CFG_DISCONNECT_CODE    = 3'd4,
    CFG_CONNECT_REPLY_CODE = 3'd5,
    CFG_CONFIRM_REPLY_CODE = 3'd6
  } cfg_idx_t;

  typedef struct packed {
    logic        role_is_server;
    logic [15:0] connect_period_ms;
    logic [7:0]  connect_code;
    logic [7:0]  confirm_code;
    logic [7:0]  disconnect_code;
    logic [7:0]  connect_reply_code;
    logic [7:0]  confirm_reply_code;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    role_is_server:     1'b0,
    connect_period_ms:  16'd1000,
    connect_code:       8'd1,
    confirm_code:       8'd2,
    disconnect_code:    8'd3,
    connect_reply_code: 8'd4,
    confirm_reply_code: 8'd5
  };

  typedef struct packed {
    logic [15:0] elapsed_ms;
    logic [7:0]  rx_batch_last_byte;
    logic [7:0]  rx_first_byte;
    logic [5:0]  rx_waiting;
  } poll_t;

  typedef struct packed {
    logic       link_up;
    logic [5:0] rx_taken;
    logic       reset_link_state;
    logic       flush_buffers;
    logic [7:0] tx_byte;
    logic       tx_valid;
  } result_t;

endpackage

// ===== src/slhs_core.sv =====
`include "serial_link_handshake_top_defines.svh"

module slhs_core #(
  parameter int READ_BATCH = slhs_pkg::READ_BATCH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              advance,
  input  slhs_pkg::poll_t   poll,
  input  slhs_pkg::cfg_t    cfg,
  output slhs_pkg::result_t res
);

  slhs_pkg::step_t step_r, step_nxt;
  logic [15:0] timer_r, timer_nxt;

  logic [5:0]                       waiting_sat;
  logic [slhs_pkg::BATCH_CMP_W-1:0] batch_wide;
  logic [slhs_pkg::BATCH_CMP_W-1:0] batch_lim;
  logic [5:0]                       batch;
  logic                             batch_ok;
  logic                             single;
  logic [16:0]                      timer_sum;
  logic [15:0]                      timer_sat;
  logic                             timed_out;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r  <= slhs_pkg::STEP_INIT1;
      timer_r <= '0;
    end else if (advance) begin
      step_r  <= step_nxt;
      timer_r <= timer_nxt;
    end
  end

  always_comb begin
    batch_lim   = slhs_pkg::BATCH_CMP_W'(READ_BATCH);
    waiting_sat = (poll.rx_waiting > slhs_pkg::RX_SAT) ? slhs_pkg::RX_SAT : poll.rx_waiting;
    batch_wide  = (slhs_pkg::BATCH_CMP_W'(waiting_sat) < batch_lim)
                  ? slhs_pkg::BATCH_CMP_W'(waiting_sat) : batch_lim;
    batch       = batch_wide[5:0];
    batch_ok    = (batch_wide != '0) && (batch_wide < batch_lim);
    single      = (waiting_sat != '0);
    timer_sum   = {1'b0, timer_r} + {1'b0, poll.elapsed_ms};
    timer_sat   = timer_sum[16] ? slhs_pkg::TIMER_MAX : timer_sum[15:0];
    timed_out   = (timer_sat >= cfg.connect_period_ms);

    res       = '0;
    step_nxt  = step_r;
    timer_nxt = timer_r;

    if (step_r == slhs_pkg::STEP_CONNECTED) begin
      res.link_up = 1'b1;
    end else if (!cfg.role_is_server) begin
      unique case (step_r)
        slhs_pkg::STEP_INIT2: begin
          timer_nxt    = timer_sat;
          res.rx_taken = batch;
          if (batch_ok && poll.rx_batch_last_byte == cfg.connect_reply_code) begin
            res.tx_valid = 1'b1;
            res.tx_byte  = cfg.confirm_code;
            timer_nxt    = '0;
            step_nxt     = slhs_pkg::STEP_INIT3;
          end else if (timed_out) begin
            step_nxt = slhs_pkg::STEP_INIT1;
          end
        end
        slhs_pkg::STEP_INIT3: begin
          timer_nxt    = timer_sat;
          res.rx_taken = {5'b0, single};
          if (single && poll.rx_first_byte == cfg.confirm_reply_code) begin
            res.reset_link_state = 1'b1;
            res.link_up          = 1'b1;
            step_nxt             = slhs_pkg::STEP_CONNECTED;
          end else if (timed_out) begin
            step_nxt = slhs_pkg::STEP_INIT1;
          end
        end
        default: begin
          res.flush_buffers = 1'b1;
          res.tx_valid      = 1'b1;
          res.tx_byte       = cfg.connect_code;
          timer_nxt         = '0;
          step_nxt          = slhs_pkg::STEP_INIT2;
        end
      endcase
    end else begin
      unique case (step_r)
        slhs_pkg::STEP_INIT2: begin
          res.flush_buffers = 1'b1;
          step_nxt          = slhs_pkg::STEP_INIT3;
        end
        slhs_pkg::STEP_INIT3: begin
          res.rx_taken = batch;
          if (batch_ok && poll.rx_batch_last_byte == cfg.connect_code) begin
            res.tx_valid = 1'b1;
            res.tx_byte  = cfg.connect_reply_code;
            step_nxt     = slhs_pkg::STEP_INIT4;
          end
        end
        slhs_pkg::STEP_INIT4: begin
          res.rx_taken = batch;
          if (batch == 6'd1 && poll.rx_first_byte == cfg.confirm_code) begin
            res.tx_valid         = 1'b1;
            res.tx_byte          = cfg.confirm_reply_code;
            res.reset_link_state = 1'b1;
            res.link_up          = 1'b1;
            step_nxt             = slhs_pkg::STEP_CONNECTED;
          end else if (batch != '0) begin
            step_nxt = slhs_pkg::STEP_INIT3;
          end
        end
        default: begin
          res.tx_valid = 1'b1;
          res.tx_byte  = cfg.disconnect_code;
          step_nxt     = slhs_pkg::STEP_INIT2;
        end
      endcase
    end
  end

  `SLHS_ASSERT_NEXT(a_connected_sticks, clk, rst_n, step_r == slhs_pkg::STEP_CONNECTED, step_r == slhs_pkg::STEP_CONNECTED, "link dropped out of connected state")
  `SLHS_ASSERT_NEXT(a_reset_pulse_connects, clk, rst_n, advance && res.reset_link_state, step_r == slhs_pkg::STEP_CONNECTED, "link reset pulse without reaching connected state")
  `SLHS_ASSERT_NEXT(a_client_start_clears_timer, clk, rst_n, advance && !cfg.role_is_server && step_r == slhs_pkg::STEP_INIT1, timer_r == '0 && step_r == slhs_pkg::STEP_INIT2, "client restart left timer running")

endmodule

// ===== src/serial_link_handshake_top.sv =====
// Serial link handshake engine.
//
// Input stream (in_*): one beat per poll of the link, carrying the receive
// queue depth, first and batch-last received bytes and elapsed milliseconds.
// Output stream (out_*): one beat per poll, giving the byte to send, flush
// and link-reset strobes, the receive bytes taken and the connected flag.
// Config channel (cfg_*): register index and data, always ready; write only
// while no poll is in flight.
//
// A poll beat is held in the input register, evaluated by the handshake
// core when the result register is free or draining, and its result beat
// is held in the result register until taken. Throughput: one poll per cycle
// while out_tready is high, the handshake step and wait timer being updated
// by a single pass of compare and add logic.
//
// Reset (rst_n low, synchronous): both stages empty, handshake back at the
// first step, wait timer cleared, config registers to their defaults.
// Stall: a held result keeps out_tdata steady; one further poll is taken
// into the input register, after which in_tready follows out_tready.
`include "serial_link_handshake_top_defines.svh"

module serial_link_handshake_top #(
  parameter int READ_BATCH = slhs_pkg::READ_BATCH
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // Poll beats
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // [5:0] rx_waiting, [13:6] rx_first_byte, [21:14] rx_batch_last_byte,
  // [37:22] elapsed_ms, [39:38] zero
  input  logic [39:0]                      in_tdata,
  // Result beats
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // [0] tx_valid, [8:1] tx_byte, [9] flush_buffers, [10] reset_link_state,
  // [16:11] rx_taken, [17] link_up, [23:18] zero
  output logic [23:0]                      out_tdata,
  // Register writes
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [slhs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [slhs_pkg::CFG_DATA_W-1:0] cfg_data
);

  slhs_pkg::cfg_t    cfg_r;
  slhs_pkg::poll_t   in_data_r;
  logic              in_valid_r;
  slhs_pkg::result_t out_data_r;
  logic              out_valid_r;
  slhs_pkg::result_t res;
  logic              advance;
  logic              in_take;

  // Evaluate the held poll whenever the result register is free or draining.
  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;
  assign in_take   = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  // Register writes; drop indexes beyond the list.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= slhs_pkg::CFG_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        slhs_pkg::CFG_ROLE_IS_SERVER:     cfg_r.role_is_server     <= cfg_data[0];
        slhs_pkg::CFG_CONNECT_PERIOD_MS:  cfg_r.connect_period_ms  <= cfg_data;
        slhs_pkg::CFG_CONNECT_CODE:       cfg_r.connect_code       <= cfg_data[7:0];
        slhs_pkg::CFG_CONFIRM_CODE:       cfg_r.confirm_code       <= cfg_data[7:0];
        slhs_pkg::CFG_DISCONNECT_CODE:    cfg_r.disconnect_code    <= cfg_data[7:0];
        slhs_pkg::CFG_CONNECT_REPLY_CODE: cfg_r.connect_reply_code <= cfg_data[7:0];
        slhs_pkg::CFG_CONFIRM_REPLY_CODE: cfg_r.confirm_reply_code <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Input stage: hold the poll until it is evaluated.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_take) begin
      in_valid_r <= 1'b1;
    end else if (advance) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_data_r.rx_waiting         <= in_tdata[5:0];
      in_data_r.rx_first_byte      <= in_tdata[13:6];
      in_data_r.rx_batch_last_byte <= in_tdata[21:14];
      in_data_r.elapsed_ms         <= in_tdata[37:22];
    end
  end

  slhs_core #(
    .READ_BATCH (READ_BATCH)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .poll    (in_data_r),
    .cfg     (cfg_r),
    .res     (res)
  );

  // Result stage: hold the beat until the receiver takes it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'b0,
                       out_data_r.link_up,
                       out_data_r.rx_taken,
                       out_data_r.reset_link_state,
                       out_data_r.flush_buffers,
                       out_data_r.tx_byte,
                       out_data_r.tx_valid};

  `SLHS_ASSERT_IMPL(a_idle_byte_zero, clk, rst_n, out_valid_r && !out_data_r.tx_valid, out_data_r.tx_byte == '0, "byte set without transmit strobe")
  `SLHS_ASSERT_IMPL(a_reset_implies_up, clk, rst_n, out_valid_r && out_data_r.reset_link_state, out_data_r.link_up, "link reset pulse without connected flag")
  `SLHS_ASSERT(a_stall_only_when_full, clk, rst_n, in_tready || (in_valid_r && out_valid_r && !out_tready), "input stalled with room to spare")

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps

module tb;

  localparam int CYCLE_LIMIT = 500000;
  localparam int SETTLE_CYCLES = 4;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [slhs_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [slhs_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  serial_link_handshake_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // Own copy of the handshake state and of the register file.
  slhs_pkg::step_t link_step = slhs_pkg::STEP_INIT1;
  logic [15:0]     wait_ms = '0;
  slhs_pkg::cfg_t  link_cfg = slhs_pkg::CFG_RESET;

  slhs_pkg::result_t pending_results[$];

  bit idling_on = 1'b1;
  int mismatches = 0;
  int polls_sent = 0;
  int results_seen = 0;
  int cfg_writes = 0;
  int tx_seen = 0;
  int flush_seen = 0;
  int cycle_count = 0;

  initial begin
    forever #10 clk = ~clk;
  end

  // Give up on a hung run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Add elapsed time to the wait timer, saturating at its top.
  function automatic void tick_wait(logic [15:0] elapsed);
    logic [16:0] sum;
    sum = {1'b0, wait_ms} + {1'b0, elapsed};
    wait_ms = sum[16] ? slhs_pkg::TIMER_MAX : sum[15:0];
  endfunction

  // Advance the handshake by one poll and return what the block must answer.
  function automatic slhs_pkg::result_t predict_link_poll(slhs_pkg::poll_t p);
    slhs_pkg::result_t r;
    logic [5:0]        batch;
    logic              batch_ok;
    r = '0;
    batch = (p.rx_waiting > slhs_pkg::RX_SAT) ? slhs_pkg::RX_SAT : p.rx_waiting;
    if (int'(batch) > slhs_pkg::READ_BATCH) batch = 6'(slhs_pkg::READ_BATCH);
    // A batch as large as the read size is consumed but never matches.
    batch_ok = (batch != 6'd0) && (int'(batch) < slhs_pkg::READ_BATCH);
    if (link_step == slhs_pkg::STEP_CONNECTED) begin
      r.link_up = 1'b1;
    end else if (!link_cfg.role_is_server) begin
      case (link_step)
        slhs_pkg::STEP_INIT2: begin
          tick_wait(p.elapsed_ms);
          r.rx_taken = batch;
          if (batch_ok && p.rx_batch_last_byte == link_cfg.connect_reply_code) begin
            r.tx_valid = 1'b1;
            r.tx_byte  = link_cfg.confirm_code;
            wait_ms    = '0;
            link_step  = slhs_pkg::STEP_INIT3;
          end else if (wait_ms >= link_cfg.connect_period_ms) begin
            link_step = slhs_pkg::STEP_INIT1;
          end
        end
        slhs_pkg::STEP_INIT3: begin
          tick_wait(p.elapsed_ms);
          r.rx_taken = (batch != 6'd0) ? 6'd1 : 6'd0;
          if (batch != 6'd0 && p.rx_first_byte == link_cfg.confirm_reply_code) begin
            r.reset_link_state = 1'b1;
            r.link_up          = 1'b1;
            link_step          = slhs_pkg::STEP_CONNECTED;
          end else if (wait_ms >= link_cfg.connect_period_ms) begin
            link_step = slhs_pkg::STEP_INIT1;
          end
        end
        // Step four has no meaning for a client: start over.
        default: begin
          r.flush_buffers = 1'b1;
          wait_ms         = '0;
          r.tx_valid      = 1'b1;
          r.tx_byte       = link_cfg.connect_code;
          link_step       = slhs_pkg::STEP_INIT2;
        end
      endcase
    end else begin
      case (link_step)
        slhs_pkg::STEP_INIT2: begin
          r.flush_buffers = 1'b1;
          link_step       = slhs_pkg::STEP_INIT3;
        end
        slhs_pkg::STEP_INIT3: begin
          r.rx_taken = batch;
          if (batch_ok && p.rx_batch_last_byte == link_cfg.connect_code) begin
            r.tx_valid = 1'b1;
            r.tx_byte  = link_cfg.connect_reply_code;
            link_step  = slhs_pkg::STEP_INIT4;
          end
        end
        slhs_pkg::STEP_INIT4: begin
          r.rx_taken = batch;
          if (batch == 6'd1 && p.rx_first_byte == link_cfg.confirm_code) begin
            r.tx_valid         = 1'b1;
            r.tx_byte          = link_cfg.confirm_reply_code;
            r.reset_link_state = 1'b1;
            r.link_up          = 1'b1;
            link_step          = slhs_pkg::STEP_CONNECTED;
          end else if (batch != 6'd0) begin
            link_step = slhs_pkg::STEP_INIT3;
          end
        end
        default: begin
          r.tx_valid = 1'b1;
          r.tx_byte  = link_cfg.disconnect_code;
          link_step  = slhs_pkg::STEP_INIT2;
        end
      endcase
    end
    return r;
  endfunction

  // Send one poll beat. Entered just after a rising edge; returns at the
  // rising edge that accepted the beat, with tvalid still high so that a
  // following beat can go out back to back.
  task automatic send_poll(slhs_pkg::poll_t p);
    @(negedge clk);
    if (idling_on && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {2'b00, p};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_results.push_back(predict_link_poll(p));
    polls_sent++;
  endtask

  task automatic poll_once(int waiting, int first, int last, int elapsed);
    slhs_pkg::poll_t p;
    p.rx_waiting         = 6'(waiting);
    p.rx_first_byte      = 8'(first);
    p.rx_batch_last_byte = 8'(last);
    p.elapsed_ms         = 16'(elapsed);
    send_poll(p);
  endtask

  // Drop tvalid and hold until every result is back.
  task automatic settle_link();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic cfg_write(slhs_pkg::cfg_idx_t idx, logic [15:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_writes++;
  endtask

  // Write all seven registers; unused upper data bits carry noise.
  task automatic apply_settings(slhs_pkg::cfg_t c);
    cfg_write(slhs_pkg::CFG_ROLE_IS_SERVER,     {15'($urandom), c.role_is_server});
    cfg_write(slhs_pkg::CFG_CONNECT_PERIOD_MS,  c.connect_period_ms);
    cfg_write(slhs_pkg::CFG_CONNECT_CODE,       {8'($urandom), c.connect_code});
    cfg_write(slhs_pkg::CFG_CONFIRM_CODE,       {8'($urandom), c.confirm_code});
    cfg_write(slhs_pkg::CFG_DISCONNECT_CODE,    {8'($urandom), c.disconnect_code});
    cfg_write(slhs_pkg::CFG_CONNECT_REPLY_CODE, {8'($urandom), c.connect_reply_code});
    cfg_write(slhs_pkg::CFG_CONFIRM_REPLY_CODE, {8'($urandom), c.confirm_reply_code});
    @(negedge clk);
    cfg_valid <= 1'b0;
    link_cfg = c;
  endtask

  function automatic logic [7:0] pick_code();
    case ($urandom_range(0, 5))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  // Random poll, biased towards what the current step is waiting for.
  function automatic slhs_pkg::poll_t craft_poll(bit shaped);
    slhs_pkg::poll_t p;
    int              sel;
    p.rx_waiting         = 6'($urandom_range(0, 63));
    p.rx_first_byte      = 8'($urandom);
    p.rx_batch_last_byte = 8'($urandom);
    sel = $urandom_range(0, 9);
    if (sel < 2)      p.elapsed_ms = 16'($urandom);
    else if (sel < 4) p.elapsed_ms = 16'd0;
    else              p.elapsed_ms = 16'($urandom_range(0, 255));
    if (shaped) begin
      if (!link_cfg.role_is_server) begin
        case (link_step)
          slhs_pkg::STEP_INIT2: begin
            p.rx_waiting = 6'($urandom_range(0, 33));
            if ($urandom_range(0, 1)) p.rx_batch_last_byte = link_cfg.connect_reply_code;
          end
          slhs_pkg::STEP_INIT3: begin
            p.rx_waiting = 6'($urandom_range(0, 3));
            if ($urandom_range(0, 1)) p.rx_first_byte = link_cfg.confirm_reply_code;
          end
          default: ;
        endcase
      end else begin
        case (link_step)
          slhs_pkg::STEP_INIT3: begin
            p.rx_waiting = 6'($urandom_range(0, 33));
            if ($urandom_range(0, 1)) p.rx_batch_last_byte = link_cfg.connect_code;
          end
          slhs_pkg::STEP_INIT4: begin
            p.rx_waiting = 6'($urandom_range(0, 3));
            if ($urandom_range(0, 1)) p.rx_first_byte = link_cfg.confirm_code;
          end
          default: ;
        endcase
      end
    end
    return p;
  endfunction

  // Nudge the one byte that would complete the handshake, so the link
  // stays down and the early steps keep getting exercised.
  function automatic slhs_pkg::poll_t hold_link_down(slhs_pkg::poll_t p);
    if (!link_cfg.role_is_server && link_step == slhs_pkg::STEP_INIT3 &&
        p.rx_waiting != 6'd0 && p.rx_first_byte == link_cfg.confirm_reply_code)
      p.rx_first_byte = p.rx_first_byte + 8'd1;
    if (link_cfg.role_is_server && link_step == slhs_pkg::STEP_INIT4 &&
        p.rx_waiting == 6'd1 && p.rx_first_byte == link_cfg.confirm_code)
      p.rx_first_byte = p.rx_first_byte + 8'd1;
    return p;
  endfunction

  // The poll that moves the handshake one step on, with no time passing.
  function automatic slhs_pkg::poll_t next_good_poll();
    slhs_pkg::poll_t p;
    p.rx_waiting         = 6'd1;
    p.rx_first_byte      = 8'($urandom);
    p.rx_batch_last_byte = 8'($urandom);
    p.elapsed_ms         = 16'd0;
    if (!link_cfg.role_is_server) begin
      if (link_step == slhs_pkg::STEP_INIT2)
        p.rx_batch_last_byte = link_cfg.connect_reply_code;
      if (link_step == slhs_pkg::STEP_INIT3) p.rx_first_byte = link_cfg.confirm_reply_code;
    end else begin
      if (link_step == slhs_pkg::STEP_INIT3) p.rx_batch_last_byte = link_cfg.connect_code;
      if (link_step == slhs_pkg::STEP_INIT4) p.rx_first_byte = link_cfg.confirm_code;
    end
    return p;
  endfunction

  // Result side: stall in random bursts while idling is on.
  initial begin
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (idling_on && $urandom_range(0, 5) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(negedge clk);
      end
      out_tready <= 1'b1;
    end
  end

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s expected %0d got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  // Compare each result beat with the oldest prediction.
  always @(posedge clk) begin
    slhs_pkg::result_t got;
    slhs_pkg::result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[17:0];
      if (pending_results.size() == 0) begin
        $error("result beat with no poll outstanding");
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        check_field("tx_valid", int'(want.tx_valid), int'(got.tx_valid));
        check_field("tx_byte", int'(want.tx_byte), int'(got.tx_byte));
        check_field("flush_buffers", int'(want.flush_buffers), int'(got.flush_buffers));
        check_field("reset_link_state", int'(want.reset_link_state),
                    int'(got.reset_link_state));
        check_field("rx_taken", int'(want.rx_taken), int'(got.rx_taken));
        check_field("link_up", int'(want.link_up), int'(got.link_up));
        results_seen++;
        if (got.tx_valid) tx_seen++;
        if (got.flush_buffers) flush_seen++;
      end
    end
  end

  // Client on reset values: timeouts, saturation, over-full and oversized
  // batches, then a role swap to server part way through.
  task automatic test_client_waits();
    slhs_pkg::cfg_t c;
    poll_once(0, 0, 0, 0);          // connect byte with flush
    poll_once(0, 0, 0, 0);          // nothing waiting
    poll_once(32, 0, 4, 10);        // batch too full for a match
    poll_once(63, 0, 4, 0);         // depth beyond saturation
    poll_once(31, 0, 3, 65535);     // timer saturates, start over
    poll_once(5, 9, 9, 0);
    poll_once(31, 0, 4, 0);         // connect reply, confirm goes out
    poll_once(0, 0, 0, 999);
    poll_once(2, 7, 7, 1);          // wrong byte, timer hits the period
    poll_once(0, 0, 0, 0);
    poll_once(1, 4, 4, 0);
    settle_link();
    c = slhs_pkg::CFG_RESET;
    c.role_is_server = 1'b1;
    apply_settings(c);
  endtask

  // Server from the step the client left behind: wrong follow-ups fall back.
  task automatic test_server_listen();
    slhs_pkg::cfg_t c;
    poll_once(31, 0, 1, 0);         // connect at the end of the batch
    poll_once(0, 0, 0, 0);
    poll_once(1, 9, 9, 0);          // lone byte, not the confirm
    poll_once(32, 1, 1, 0);         // batch too full
    poll_once(1, 1, 1, 0);
    poll_once(2, 2, 2, 0);          // confirm not alone
    poll_once(1, 1, 1, 0);
    settle_link();
    c = slhs_pkg::CFG_RESET;
    apply_settings(c);
  endtask

  // Client sitting on server step four restarts; then a zero period.
  task automatic test_odd_steps();
    slhs_pkg::cfg_t c;
    poll_once(0, 0, 0, 0);
    settle_link();
    c = slhs_pkg::CFG_RESET;
    c.connect_period_ms = 16'd0;
    apply_settings(c);
    poll_once(0, 0, 0, 0);          // times out on the spot
    poll_once(0, 0, 0, 0);
    poll_once(3, 0, 4, 0);
    poll_once(0, 0, 0, 0);
    settle_link();
    c = slhs_pkg::CFG_RESET;
    c.role_is_server = 1'b1;
    apply_settings(c);
    poll_once(0, 0, 0, 0);          // disconnect byte
    poll_once(0, 0, 0, 0);          // flush
  endtask

  // Random registers per phase, mostly step-shaped polls, link kept down.
  task automatic test_random_phases();
    slhs_pkg::cfg_t  c;
    slhs_pkg::poll_t p;
    for (int ph = 0; ph < 7; ph++) begin
      settle_link();
      c.role_is_server = ph[0];
      case ($urandom_range(0, 4))
        0:       c.connect_period_ms = 16'd1;
        1:       c.connect_period_ms = 16'hFFFF;
        2:       c.connect_period_ms = 16'($urandom_range(1, 600));
        3:       c.connect_period_ms = 16'($urandom);
        default: c.connect_period_ms = 16'($urandom_range(200, 3000));
      endcase
      c.connect_code       = pick_code();
      c.confirm_code       = pick_code();
      c.disconnect_code    = pick_code();
      c.connect_reply_code = pick_code();
      c.confirm_reply_code = pick_code();
      apply_settings(c);
      for (int i = 0; i < 180; i++) begin
        if (i % 40 == 0) idling_on = ($urandom_range(0, 3) != 0);
        p = craft_poll($urandom_range(0, 4) != 0);
        send_poll(hold_link_down(p));
      end
    end
  endtask

  // Bring the link up in a random role, then poll it while connected.
  task automatic test_link_up();
    slhs_pkg::cfg_t  c;
    slhs_pkg::poll_t p;
    int              tries;
    idling_on = 1'b0;
    settle_link();
    c.role_is_server     = 1'($urandom_range(0, 1));
    c.connect_period_ms  = 16'($urandom_range(1, 65535));
    c.connect_code       = pick_code();
    c.confirm_code       = pick_code();
    c.disconnect_code    = pick_code();
    c.connect_reply_code = pick_code();
    c.confirm_reply_code = pick_code();
    apply_settings(c);
    tries = 0;
    while (link_step != slhs_pkg::STEP_CONNECTED && tries < 20) begin
      send_poll(next_good_poll());
      tries++;
    end
    for (int i = 0; i < 40; i++) begin
      p = craft_poll(1'b0);
      send_poll(p);
    end
  endtask

  initial begin
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    test_client_waits();
    test_server_listen();
    test_odd_steps();
    test_random_phases();
    test_link_up();

    // Drain, then allow the pipeline to show any stray beat.
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (pending_results.size() != 0) begin
      $error("%0d results never arrived", pending_results.size());
      mismatches++;
    end

    $display("Checked %0d results from %0d polls after %0d register writes,",
             results_seen, polls_sent, cfg_writes);
    $display("both roles, timeouts and role swaps; %0d sends, %0d flushes, link up as %s.",
             tx_seen, flush_seen, link_cfg.role_is_server ? "server" : "client");
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
